### design/tbp_pkg.sv
// Shared types and constants of the token-bucket policer table.
`timescale 1ns / 1ps
package tbp_pkg;

  localparam int unsigned IDX_W   = 12;
  localparam int unsigned LEN_W   = 16;
  localparam int unsigned TIME_W  = 64;
  localparam int unsigned RATE_W  = 40;
  localparam int unsigned BURST_W = 32;
  localparam int unsigned TOK_W   = 32;
  localparam int unsigned CNT_W   = 64;

  localparam int unsigned IN_DATA_W  = 168;
  localparam int unsigned OUT_DATA_W = 160;

  localparam logic FUNC_POLICE    = 1'b0;
  localparam logic FUNC_CONFIGURE = 1'b1;

  // One bucket row of the table.
  typedef struct packed {
    logic [RATE_W-1:0]  rate;
    logic [BURST_W-1:0] burst;
    logic [TOK_W-1:0]   tokens;
    logic [TIME_W-1:0]  last_time;
    logic               time_valid;
    logic [CNT_W-1:0]   passed;
    logic [CNT_W-1:0]   dropped;
  } entry_t;

endpackage

### design/tbp_mem.sv
// Bucket table memory: one write port, one read port with registered data.
`timescale 1ns / 1ps
module tbp_mem
  import tbp_pkg::*;
#(
  parameter int unsigned DEPTH  = 8192,
  parameter int unsigned ADDR_W = 13
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  entry_t            wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output entry_t            rd_data
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### design/tbp_refill.sv
// Refill unit: floor(floor(elapsed/1000) * rate sat 64 / 1000000) on one 32x32 multiplier.
`timescale 1ns / 1ps
module tbp_refill
  import tbp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [TIME_W-1:0] elapsed,
  input  logic [RATE_W-1:0] rate,
  output logic              done,
  output logic [TIME_W-1:0] refill
);

  localparam logic [1:0] P_IDLE = 2'd0;
  localparam logic [1:0] P_DIV1 = 2'd1;
  localparam logic [1:0] P_MUL  = 2'd2;
  localparam logic [1:0] P_DIV2 = 2'd3;

  // x/1000 = ((x>>3) * M_US) >> 68 and x/1000000 = ((x>>6) * M_S) >> 72, exact for 64-bit x
  localparam logic [63:0] M_US = 64'(((128'd1 << 68) + 128'd124) / 128'd125);
  localparam logic [63:0] M_S  = 64'(((128'd1 << 72) + 128'd15624) / 128'd15625);

  logic [1:0]        phase_r;
  logic [1:0]        step_r;
  logic [63:0]       a_r;
  logic [63:0]       b_r;
  logic [RATE_W-1:0] rate_r;
  logic [127:0]      acc_r;
  logic [TIME_W-1:0] refill_r;
  logic              done_r;

  logic [31:0]       a_part;
  logic [31:0]       b_part;
  logic [63:0]       pp;
  logic [127:0]      pp_sh;
  logic [127:0]      acc_nxt;
  logic [TIME_W-1:0] prod_sat;
  logic              last_step;

  // one 32x32 partial product per cycle, four per 64x64 product
  always_comb begin
    a_part = step_r[0] ? a_r[63:32] : a_r[31:0];
    b_part = step_r[1] ? b_r[63:32] : b_r[31:0];
    pp     = {32'b0, a_part} * {32'b0, b_part};
    case (step_r)
      2'd0:    pp_sh = {64'b0, pp};
      2'd3:    pp_sh = {pp, 64'b0};
      default: pp_sh = {32'b0, pp, 32'b0};
    endcase
    acc_nxt   = acc_r + pp_sh;
    prod_sat  = (acc_nxt[127:64] != '0) ? '1 : acc_nxt[63:0];
    last_step = (step_r == 2'd3);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= P_IDLE;
      step_r  <= '0;
      done_r  <= 1'b0;
    end else begin
      done_r <= (phase_r == P_DIV2) && last_step;
      case (phase_r)
        P_IDLE: begin
          if (start) begin
            phase_r <= P_DIV1;
            step_r  <= '0;
            acc_r   <= '0;
            a_r     <= {3'b000, elapsed[TIME_W-1:3]};
            b_r     <= M_US;
            rate_r  <= rate;
          end
        end
        P_DIV1, P_MUL, P_DIV2: begin
          step_r <= step_r + 2'd1;
          acc_r  <= last_step ? '0 : acc_nxt;
          if (last_step && phase_r == P_DIV1) begin
            // microseconds times the rate
            phase_r <= P_MUL;
            a_r     <= {4'b0, acc_nxt[127:68]};
            b_r     <= {24'b0, rate_r};
          end else if (last_step && phase_r == P_MUL) begin
            phase_r <= P_DIV2;
            a_r     <= {6'b0, prod_sat[63:6]};
            b_r     <= M_S;
          end else if (last_step) begin
            phase_r  <= P_IDLE;
            refill_r <= {8'b0, acc_nxt[127:72]};
          end
        end
        default: phase_r <= P_IDLE;
      endcase
    end
  end

  assign done   = done_r;
  assign refill = refill_r;

endmodule

### design/token_bucket_policer_table.sv
// Token-bucket policer table top level: sequencer, memory and refill unit.
`timescale 1ns / 1ps
// Per-flow policer with an egress and an ingress bucket per entry, kept in one
// synchronous table memory of 2*TABLE_ENTRIES rows. After reset the block
// clears the table, one row per cycle, with in_tready low. Each item is then
// taken one at a time: a configure item or an out-of-range entry goes from
// idle straight to the output state; a police item reads its bucket row, and
// on a live bucket waits for the refill unit (three 64 by 64 products, two of
// them by reciprocal, each built from four 32 by 32 partial products, one per
// cycle) before write-back. A new item is accepted while a previous result
// waits on out_.
module token_bucket_policer_table
  import tbp_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 4096
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // entry_index[11:0], direction[12], packet_length[28:13], now_ns[92:29],
  // new_rate[132:93], new_burst[164:133], zero fill [167:165]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // func[0]
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // tokens_left[31:0], passed_bytes[95:32], dropped_bytes[159:96]
  output logic [OUT_DATA_W-1:0] out_tdata,
  // allow[0]
  output logic                  out_tuser
);

  localparam int unsigned BUCKETS = 2 * TABLE_ENTRIES;
  localparam int unsigned ADDR_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_CALC  = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0]        state_r;
  logic [ADDR_W:0]   clr_cnt_r;
  logic [ADDR_W-1:0] addr_r;
  logic [LEN_W-1:0]  len_r;
  logic [TIME_W-1:0] now_r;
  entry_t            ent_r;

  logic              res_allow_r;
  logic [TOK_W-1:0]  res_tok_r;
  logic [CNT_W-1:0]  res_pass_r;
  logic [CNT_W-1:0]  res_drop_r;
  logic              out_tvalid_r;

  logic [IDX_W-1:0]   f_idx;
  logic               f_dir;
  logic [LEN_W-1:0]   f_len;
  logic [TIME_W-1:0]  f_now;
  logic [RATE_W-1:0]  f_rate;
  logic [BURST_W-1:0] f_burst;
  logic               in_range;
  logic [ADDR_W-1:0]  bucket;
  logic               accept;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  entry_t            wr_data;
  entry_t            rd_data;

  logic [TIME_W-1:0] elapsed;
  logic              rf_start;
  logic              rf_done;
  logic [TIME_W-1:0] refill;

  logic [32:0]       sum;
  logic [TOK_W-1:0]  capped;
  logic              pass;
  logic [TOK_W-1:0]  tok_new;
  logic [CNT_W-1:0]  pass_new;
  logic [CNT_W-1:0]  drop_new;

  assign f_idx   = in_tdata[11:0];
  assign f_dir   = in_tdata[12];
  assign f_len   = in_tdata[28:13];
  assign f_now   = in_tdata[92:29];
  assign f_rate  = in_tdata[132:93];
  assign f_burst = in_tdata[164:133];

  assign in_range = (32'(f_idx) < TABLE_ENTRIES);
  assign bucket   = ADDR_W'(32'(f_idx) + (f_dir ? TABLE_ENTRIES : 32'd0));
  assign in_tready = (state_r == S_IDLE);
  assign accept   = in_tvalid && in_tready;

  assign elapsed  = now_r - (rd_data.time_valid ? rd_data.last_time : now_r);
  assign rf_start = (state_r == S_READ) && (rd_data.rate != '0);

  always_comb begin
    sum     = {1'b0, ent_r.tokens} + {1'b0, refill[TOK_W-1:0]};
    if (refill > TIME_W'(ent_r.burst) || sum > 33'(ent_r.burst)) begin
      capped = ent_r.burst;
    end else begin
      capped = sum[TOK_W-1:0];
    end
    pass     = (capped >= TOK_W'(len_r));
    tok_new  = pass ? capped - TOK_W'(len_r) : capped;
    pass_new = ent_r.passed + (pass ? CNT_W'(len_r) : '0);
    drop_new = ent_r.dropped + (pass ? '0 : CNT_W'(len_r));
  end

  // single write port: clearing, configure, or write-back
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = addr_r;
    wr_data = '0;
    case (state_r)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_cnt_r[ADDR_W-1:0];
      end
      S_IDLE: begin
        wr_en         = accept && in_range && (in_tuser == FUNC_CONFIGURE);
        wr_addr       = bucket;
        wr_data.rate  = f_rate;
        wr_data.burst = f_burst;
      end
      S_CALC: begin
        wr_en              = rf_done;
        wr_data.rate       = ent_r.rate;
        wr_data.burst      = ent_r.burst;
        wr_data.tokens     = tok_new;
        wr_data.last_time  = now_r;
        wr_data.time_valid = 1'b1;
        wr_data.passed     = pass_new;
        wr_data.dropped    = drop_new;
      end
      default: wr_en = 1'b0;
    endcase
  end

  tbp_mem #(
    .DEPTH  (BUCKETS),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (accept),
    .rd_addr (bucket),
    .rd_data (rd_data)
  );

  tbp_refill u_refill (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (rf_start),
    .elapsed (elapsed),
    .rate    (rd_data.rate),
    .done    (rf_done),
    .refill  (refill)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_cnt_r    <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (state_r == S_OUT && (!out_tvalid_r || out_tready)) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == (ADDR_W+1)'(BUCKETS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            addr_r      <= bucket;
            len_r       <= f_len;
            now_r       <= f_now;
            res_allow_r <= 1'b1;
            res_tok_r   <= '0;
            res_pass_r  <= '0;
            res_drop_r  <= '0;
            if (in_range && (in_tuser == FUNC_POLICE)) begin
              state_r <= S_READ;
            end else begin
              state_r <= S_OUT;
            end
          end
        end
        S_READ: begin
          ent_r <= rd_data;
          if (rd_data.rate == '0) begin
            // zero rate: pass, report stored state unchanged
            res_tok_r  <= rd_data.tokens;
            res_pass_r <= rd_data.passed;
            res_drop_r <= rd_data.dropped;
            state_r    <= S_OUT;
          end else begin
            state_r <= S_CALC;
          end
        end
        S_CALC: begin
          if (rf_done) begin
            res_allow_r <= pass;
            res_tok_r   <= tok_new;
            res_pass_r  <= pass_new;
            res_drop_r  <= drop_new;
            state_r     <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_tvalid_r || out_tready) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_OUT && (!out_tvalid_r || out_tready)) begin
      out_tuser <= res_allow_r;
      out_tdata <= {res_drop_r, res_pass_r, res_tok_r};
    end
  end

  assign out_tvalid = out_tvalid_r;

endmodule

### bench/tb_token_bucket_policer_table.sv
// Testbench for the token-bucket policer table: directed rows, random traffic, predictor.
`timescale 1ns / 1ps
module tb_token_bucket_policer_table;
  import tbp_pkg::*;

  localparam int unsigned ENTRIES  = 4096;
  localparam int unsigned BUCKETS  = 2 * ENTRIES;
  localparam int unsigned N_RANDOM = 1500;
  localparam int unsigned IDLE_MAX = 30000;

  typedef struct packed {
    logic              func;
    logic [IDX_W-1:0]  idx;
    logic              dir;
    logic [LEN_W-1:0]  len;
    logic [TIME_W-1:0] now;
    logic [RATE_W-1:0] rate;
    logic [BURST_W-1:0] burst;
  } pkt_t;

  typedef struct packed {
    logic               allow;
    logic [TOK_W-1:0]   tokens;
    logic [CNT_W-1:0]   passed;
    logic [CNT_W-1:0]   dropped;
  } verdict_t;

  typedef struct packed {
    pkt_t     pkt;
    logic     typed;
    verdict_t want;
  } row_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata;
  logic in_tuser;
  logic out_tvalid;
  logic out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic out_tuser;

  token_bucket_policer_table #(.TABLE_ENTRIES(ENTRIES)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  // Bucket state mirror
  logic [RATE_W-1:0]  rate_mem    [BUCKETS];
  logic [BURST_W-1:0] burst_mem   [BUCKETS];
  logic [TOK_W-1:0]   tok_mem     [BUCKETS];
  logic [TIME_W-1:0]  last_mem    [BUCKETS];
  logic               tvalid_mem  [BUCKETS];
  logic [CNT_W-1:0]   pass_mem    [BUCKETS];
  logic [CNT_W-1:0]   drop_mem    [BUCKETS];

  verdict_t verdicts_due[$];
  int       errors = 0;
  int       idle_cycles = 0;
  logic     hold_off_req = 1'b0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic verdict_t police_bucket(pkt_t p);
    verdict_t v;
    int unsigned b;
    logic [TIME_W-1:0] elapsed;
    logic [127:0] prod;
    logic [63:0] refill;
    logic [64:0] sum;
    logic [64:0] tok;
    v = '{allow: 1'b1, tokens: '0, passed: '0, dropped: '0};
    b = 32'({p.dir, p.idx});
    if (p.func == FUNC_CONFIGURE) begin
      rate_mem[b] = p.rate;
      burst_mem[b] = p.burst;
      tok_mem[b] = '0;
      last_mem[b] = '0;
      tvalid_mem[b] = 1'b0;
      pass_mem[b] = '0;
      drop_mem[b] = '0;
      return v;
    end
    if (rate_mem[b] != '0) begin
      if (!tvalid_mem[b]) begin
        last_mem[b] = p.now;
        tvalid_mem[b] = 1'b1;
      end
      elapsed = p.now - last_mem[b];
      prod = (128'(elapsed) / 128'd1000) * 128'(rate_mem[b]);
      if (prod[127:64] != '0) prod = 128'(64'hFFFF_FFFF_FFFF_FFFF);
      refill = 64'(prod / 128'd1000000);
      sum = 65'(tok_mem[b]) + 65'(refill);
      if (sum[64]) sum = 65'(64'hFFFF_FFFF_FFFF_FFFF);
      tok = (sum > 65'(burst_mem[b])) ? 65'(burst_mem[b]) : sum;
      last_mem[b] = p.now;
      if (tok >= 65'(p.len)) begin
        tok_mem[b] = 32'(tok - 65'(p.len));
        pass_mem[b] = pass_mem[b] + 64'(p.len);
      end else begin
        tok_mem[b] = 32'(tok);
        drop_mem[b] = drop_mem[b] + 64'(p.len);
        v.allow = 1'b0;
      end
    end
    v.tokens = tok_mem[b];
    v.passed = pass_mem[b];
    v.dropped = drop_mem[b];
    return v;
  endfunction

  task automatic offer(pkt_t p, logic typed, verdict_t want);
    verdict_t got;
    int gap;
    in_tdata <= {3'b000, p.burst, p.rate, p.now, p.len, p.dir, p.idx};
    in_tuser <= p.func;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    got = police_bucket(p);
    verdicts_due.push_back(typed ? want : got);
    // mostly short gaps, now and then a long one, often none
    case ($urandom_range(0, 9))
      0, 1, 2, 3: gap = 0;
      9:          gap = $urandom_range(50, 300);
      default:    gap = $urandom_range(1, 4);
    endcase
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic pkt_t mk(logic f, logic [11:0] i, logic d, logic [15:0] l,
                              logic [63:0] n, logic [39:0] r, logic [31:0] bu);
    pkt_t p;
    p = '{func: f, idx: i, dir: d, len: l, now: n, rate: r, burst: bu};
    return p;
  endfunction

  // Receiver: random back-pressure plus one long hold-off on request
  initial begin
    int stall;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_off_req) begin
        out_tready <= 1'b0;
        repeat (1200) @(posedge clk);
        hold_off_req = 1'b0;
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: stall = 0;
        9:             stall = $urandom_range(40, 400);
        default:       stall = $urandom_range(1, 5);
      endcase
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 200)) @(posedge clk);
    end
  end

  // Compare each result with the oldest pending verdict
  always @(posedge clk) begin
    verdict_t w;
    if (rst_n && out_tvalid && out_tready) begin
      if (verdicts_due.size() == 0) begin
        $display("%0t: unexpected result allow=%0b data=%h", $time, out_tuser, out_tdata);
        errors++;
      end else begin
        w = verdicts_due.pop_front();
        if (out_tuser !== w.allow) begin
          $display("%0t: allow expected %0b got %0b", $time, w.allow, out_tuser);
          errors++;
        end
        if (out_tdata[31:0] !== w.tokens) begin
          $display("%0t: tokens_left expected %0d got %0d", $time, w.tokens, out_tdata[31:0]);
          errors++;
        end
        if (out_tdata[95:32] !== w.passed) begin
          $display("%0t: passed_bytes expected %0d got %0d", $time, w.passed,
                   out_tdata[95:32]);
          errors++;
        end
        if (out_tdata[159:96] !== w.dropped) begin
          $display("%0t: dropped_bytes expected %0d got %0d", $time, w.dropped,
                   out_tdata[159:96]);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no item moving on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_MAX) begin
      $display("tb_token_bucket_policer_table: errors");
      $finish;
    end
  end

  initial begin
    row_t rows[$];
    verdict_t zero_v;
    pkt_t p;
    logic [63:0] clock_ns;
    logic [11:0] pool[6];
    logic [11:0] idx;
    logic d;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    for (int k = 0; k < BUCKETS; k++) begin
      rate_mem[k] = '0; burst_mem[k] = '0; tok_mem[k] = '0; last_mem[k] = '0;
      tvalid_mem[k] = 1'b0; pass_mem[k] = '0; drop_mem[k] = '0;
    end
    zero_v = '{allow: 1'b1, tokens: '0, passed: '0, dropped: '0};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // unconfigured bucket passes with zero state
    rows.push_back('{mk(FUNC_POLICE, 12'd0, 1'b0, 16'hFFFF, 64'd5, 40'd0, 32'd0), 1'b1, zero_v});
    rows.push_back('{mk(FUNC_CONFIGURE, 12'hFFF, 1'b1, 16'd0, 64'd0, 40'hFF_FFFF_FFFF,
                        32'hFFFF_FFFF), 1'b1, zero_v});
    // first packet: no elapsed time, empty bucket passes a zero-length packet
    rows.push_back('{mk(FUNC_POLICE, 12'hFFF, 1'b1, 16'd0, 64'hFFFF_FFFF_FFFF_FFFF, 40'd0,
                        32'd0), 1'b1, zero_v});
    // time steps back by wrap to 1 ns: no refill, drop
    rows.push_back('{mk(FUNC_POLICE, 12'hFFF, 1'b1, 16'hFFFF, 64'd0, 40'd0, 32'd0), 1'b1,
                     '{allow: 1'b0, tokens: 32'd0, passed: 64'd0, dropped: 64'd65535}});
    // huge elapsed: product saturates, bucket fills to burst
    rows.push_back('{mk(FUNC_POLICE, 12'hFFF, 1'b1, 16'hFFFF, 64'h8000_0000_0000_0000, 40'd0,
                        32'd0), 1'b1,
                     '{allow: 1'b1, tokens: 32'hFFFF_0000, passed: 64'd65535,
                       dropped: 64'd65535}});
    rows.push_back('{mk(FUNC_POLICE, 12'hFFF, 1'b1, 16'd1, 64'hFFFF_FFFF_FFFF_FFFF, 40'd0,
                        32'd0), 1'b0, zero_v});
    rows.push_back('{mk(FUNC_CONFIGURE, 12'd0, 1'b0, 16'd0, 64'd0, 40'd1000000, 32'd5000),
                     1'b1, zero_v});
    rows.push_back('{mk(FUNC_POLICE, 12'd0, 1'b0, 16'd100, 64'd1000, 40'd0, 32'd0), 1'b0, zero_v});
    rows.push_back('{mk(FUNC_POLICE, 12'd0, 1'b0, 16'd100, 64'd3000000, 40'd0, 32'd0), 1'b0,
                     zero_v});
    rows.push_back('{mk(FUNC_POLICE, 12'd0, 1'b0, 16'd5000, 64'd1000000000, 40'd0, 32'd0), 1'b0,
                     zero_v});
    rows.push_back('{mk(FUNC_POLICE, 12'd0, 1'b0, 16'd4999, 64'd2000000000, 40'd0, 32'd0), 1'b0,
                     zero_v});
    rows.push_back('{mk(FUNC_CONFIGURE, 12'd1, 1'b0, 16'd0, 64'd0, 40'd1, 32'd1), 1'b1, zero_v});
    rows.push_back('{mk(FUNC_POLICE, 12'd1, 1'b0, 16'd1, 64'd0, 40'd0, 32'd0), 1'b0, zero_v});
    rows.push_back('{mk(FUNC_POLICE, 12'd1, 1'b0, 16'd1, 64'hFFFF_FFFF_FFFF, 40'd0, 32'd0),
                     1'b0, zero_v});
    // rate zero disables policing again
    rows.push_back('{mk(FUNC_CONFIGURE, 12'd0, 1'b0, 16'd0, 64'd0, 40'd0, 32'd77), 1'b1, zero_v});
    rows.push_back('{mk(FUNC_POLICE, 12'd0, 1'b0, 16'd9, 64'd10, 40'd0, 32'd0), 1'b1, zero_v});
    foreach (rows[k]) offer(rows[k].pkt, rows[k].typed, rows[k].want);

    pool[0] = 12'd0; pool[1] = 12'hFFF; pool[2] = 12'd1; pool[3] = 12'h555;
    pool[4] = 12'hAAA; pool[5] = 12'(($urandom));
    clock_ns = 64'd1000;
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM / 3) hold_off_req = 1'b1;
      if (n == N_RANDOM / 2) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
        wait (verdicts_due.size() == 0);
        @(posedge clk);
      end
      idx = pool[$urandom_range(0, 5)];
      d = 1'($urandom);
      clock_ns = clock_ns + 64'($urandom_range(0, 3000000));
      if ($urandom_range(0, 49) == 0) clock_ns = clock_ns + ({$urandom, $urandom} >> 8);
      p = mk(FUNC_POLICE, idx, d, 16'($urandom_range(0, 1600)), clock_ns, 40'd0, 32'd0);
      case ($urandom_range(0, 19))
        0, 1: begin
          p.func = FUNC_CONFIGURE;
          p.rate = 40'($urandom_range(1000, 2000000000));
          p.burst = 32'($urandom_range(0, 100000));
          p.now = 64'(($urandom));
        end
        2: begin
          // noise: any values in any field
          p.func = 1'($urandom);
          p.idx = 12'($urandom);
          p.len = 16'($urandom);
          p.now = {$urandom, $urandom};
          p.rate = {8'($urandom), 32'($urandom)};
          p.burst = $urandom;
        end
        3: p.len = 16'($urandom);
        default: ;
      endcase
      offer(p, 1'b0, zero_v);
    end
    in_tvalid <= 1'b0;
    wait (verdicts_due.size() == 0);
    repeat (400) @(posedge clk);
    if (errors == 0) begin
      $display("tb_token_bucket_policer_table: clean");
    end else begin
      $display("tb_token_bucket_policer_table: errors");
    end
    $finish;
  end

endmodule
